// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the delay line modules.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property checked at every rising edge outside reset.
`define ASSERT_AT(label, clk, rst, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// Condition in one cycle implies the consequence in the next.
`define ASSERT_NEXT(label, clk, rst, cond, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`endif

// ===== hw/rtl/fdl_pkg.sv =====
package fdl_pkg;

  typedef struct packed {
    logic advance;
    logic load;
  } pipe_ctrl_t;

endpackage

// ===== hw/rtl/fdl_store.sv =====
`include "assert_macros.svh"

module fdl_store #(
  parameter int MAX_DELAY = 1023,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS = 16,
  localparam int AW = $clog2(MAX_DELAY + 1),
  localparam int DELAY_BITS = AW + FRAC_BITS
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fdl_pkg::pipe_ctrl_t           ctrl,
  input  logic signed [SAMPLE_BITS-1:0] sample,
  input  logic [DELAY_BITS-1:0]         delay,
  output logic                          valid,
  output logic signed [SAMPLE_BITS-1:0] x1,
  output logic signed [SAMPLE_BITS-1:0] x2,
  output logic [FRAC_BITS-1:0]          frac
);
  import fdl_pkg::*;

  localparam int DEPTH = MAX_DELAY + 1;
  localparam logic [AW:0] DEPTH_W = (AW + 1)'(DEPTH);
  localparam logic [AW:0] MAX_W = (AW + 1)'(MAX_DELAY);
  localparam logic [AW-1:0] HEAD_LAST = AW'(MAX_DELAY);
  localparam logic [AW-1:0] HEAD_ONE = AW'(1);

  logic signed [SAMPLE_BITS-1:0] mem [DEPTH];

  logic [AW-1:0] head;
  logic [AW-1:0] head_next;
  logic          full;

  logic [AW-1:0] whole;
  logic          sat;
  logic [AW:0]   head_w;
  logic [AW:0]   w1;
  logic [AW:0]   w2;
  logic [AW:0]   pos1_w;
  logic [AW:0]   pos2_w;
  logic [AW-1:0] pos1;
  logic [AW-1:0] pos2;

  logic signed [SAMPLE_BITS-1:0] rd1;
  logic signed [SAMPLE_BITS-1:0] rd2;
  logic signed [SAMPLE_BITS-1:0] sample_q;
  logic                          fwd1;
  logic                          fwd2;
  logic                          ok1;
  logic                          ok2;

  // Entries at or past the head hold data only once the store has wrapped;
  // before that they read as zero, which matches a cleared store.
  always_comb begin
    whole = delay[DELAY_BITS-1:FRAC_BITS];
    sat = {1'b0, whole} >= MAX_W;
    head_w = {1'b0, head};
    w1 = sat ? MAX_W : {1'b0, whole};
    w2 = w1 + (AW + 1)'(1);
    pos1_w = (head_w >= w1) ? head_w - w1 : head_w + DEPTH_W - w1;
    pos2_w = (head_w >= w2) ? head_w - w2 : head_w + DEPTH_W - w2;
    pos1 = pos1_w[AW-1:0];
    pos2 = pos2_w[AW-1:0];
    head_next = (head == HEAD_LAST) ? '0 : head + HEAD_ONE;
  end

  always_ff @(posedge clk) begin
    if (ctrl.load) begin
      mem[head] <= sample;
    end
    if (ctrl.advance) begin
      rd1 <= mem[pos1];
      rd2 <= mem[pos2];
      sample_q <= sample;
      fwd1 <= pos1 == head;
      fwd2 <= pos2 == head;
      ok1 <= full || (pos1 < head);
      ok2 <= full || (pos2 < head);
      frac <= sat ? '0 : delay[FRAC_BITS-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      head <= '0;
      full <= 1'b0;
      valid <= 1'b0;
    end else begin
      if (ctrl.advance) begin
        valid <= ctrl.load;
      end
      if (ctrl.load) begin
        head <= head_next;
        if (head == HEAD_LAST) begin
          full <= 1'b1;
        end
      end
    end
  end

  assign x1 = fwd1 ? sample_q : (ok1 ? rd1 : '0);
  assign x2 = fwd2 ? sample_q : (ok2 ? rd2 : '0);

  `ASSERT_NEXT(a_head_step, clk, rst, ctrl.load && (head != HEAD_LAST), head == $past(head) + HEAD_ONE, "head did not advance by one")
  `ASSERT_AT(a_full_at_wrap, clk, rst, $rose(full) |-> (head == '0), "store marked full away from wrap")

endmodule

// ===== hw/rtl/fdl_interp.sv =====
module fdl_interp #(
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS = 16
) (
  input  logic                          clk,
  input  logic                          rst,
  input  fdl_pkg::pipe_ctrl_t           ctrl,
  input  logic                          valid_in,
  input  logic signed [SAMPLE_BITS-1:0] x1,
  input  logic signed [SAMPLE_BITS-1:0] x2,
  input  logic [FRAC_BITS-1:0]          frac,
  output logic                          y_valid,
  output logic signed [SAMPLE_BITS-1:0] y
);
  import fdl_pkg::*;

  localparam int PW = FRAC_BITS + SAMPLE_BITS + 2;

  logic                          a_valid;
  logic signed [SAMPLE_BITS-1:0] a_x1;
  logic signed [SAMPLE_BITS:0]   a_diff;
  logic [FRAC_BITS-1:0]          a_frac;

  logic                          b_valid;
  logic signed [SAMPLE_BITS-1:0] b_x1;
  logic signed [PW-1:0]          b_prod;
  logic signed [PW-1:0]          b_shift;

  always_ff @(posedge clk) begin
    if (ctrl.advance) begin
      a_x1 <= x1;
      a_diff <= $signed({x2[SAMPLE_BITS-1], x2}) - $signed({x1[SAMPLE_BITS-1], x1});
      a_frac <= frac;
      b_x1 <= a_x1;
      b_prod <= $signed({1'b0, a_frac}) * a_diff;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
      b_valid <= 1'b0;
    end else if (ctrl.advance) begin
      a_valid <= valid_in;
      b_valid <= a_valid;
    end
  end

  // The arithmetic shift floors; the sum always lies between the two samples.
  assign b_shift = b_prod >>> FRAC_BITS;
  assign y = b_x1 + b_shift[SAMPLE_BITS-1:0];
  assign y_valid = b_valid;

endmodule

// ===== hw/rtl/fdl_out.sv =====
`include "assert_macros.svh"

module fdl_out #(
  parameter int SAMPLE_BITS = 24
) (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   y_valid,
  input  logic [SAMPLE_BITS-1:0] y,
  output logic                   advance,
  output logic                   tvalid,
  input  logic                   tready,
  output logic [SAMPLE_BITS-1:0] value
);

  logic                   skid_valid;
  logic [SAMPLE_BITS-1:0] skid;

  assign advance = !skid_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      tvalid <= 1'b0;
      skid_valid <= 1'b0;
    end else if (skid_valid) begin
      if (tready) begin
        skid_valid <= 1'b0;
      end
    end else if (!tvalid || tready) begin
      tvalid <= y_valid;
    end else if (y_valid) begin
      skid_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (skid_valid) begin
      if (tready) begin
        value <= skid;
      end
    end else if (!tvalid || tready) begin
      value <= y;
    end else begin
      skid <= y;
    end
  end

  `ASSERT_AT(a_skid_behind_out, clk, rst, skid_valid |-> tvalid, "skid holds data with output empty")
  `ASSERT_NEXT(a_skid_drain, clk, rst, skid_valid && tready, !skid_valid, "skid not drained after transaction")

endmodule

// ===== hw/rtl/fractional_delay_line.sv =====
// Fractional delay line with linear interpolation for one audio stream.
// Each transaction on the s_axis side carries a signed sample and an
// unsigned delay with FRAC_BITS fraction bits. The sample is written at
// the head of a circular store of MAX_DELAY+1 entries, the output is read
// at the given delay (zero returns the sample just written) by linear
// interpolation between the two neighboring samples, and the head advances.
// Delays whose whole part reaches MAX_DELAY saturate there and drop the
// fraction. Each input produces exactly one m_axis transaction.
// Throughput is one transaction per cycle while the skid register is empty:
// the store has one write port and two read ports, so both neighbors are
// fetched in the accept cycle. From acceptance to m_axis_tvalid a result
// passes the memory read, difference, multiply and output registers.
// Reset clears the head and the wrap flag; entries not yet written since
// reset read as zero, so no clearing pass is needed and s_axis_tready
// rises in the cycle after reset.
// When the receiver stalls, a skid register catches one result and
// s_axis_tready drops until the skid drains; nothing is lost or repeated.
module fractional_delay_line #(
  parameter int MAX_DELAY = 1023,
  parameter int SAMPLE_BITS = 24,
  parameter int FRAC_BITS = 16,
  localparam int AW = $clog2(MAX_DELAY + 1),
  localparam int DELAY_BITS = AW + FRAC_BITS,
  localparam int IN_BITS = SAMPLE_BITS + DELAY_BITS,
  localparam int IN_TDATA_BITS = ((IN_BITS + 7) / 8) * 8,
  localparam int OUT_TDATA_BITS = ((SAMPLE_BITS + 7) / 8) * 8
) (
  input  logic                      clk,
  input  logic                      rst,
  input  logic                      s_axis_tvalid,
  output logic                      s_axis_tready,
  // Fields from bit 0 up: sample, delay.
  input  logic [IN_TDATA_BITS-1:0]  s_axis_tdata,
  output logic                      m_axis_tvalid,
  input  logic                      m_axis_tready,
  // Fields from bit 0 up: value.
  output logic [OUT_TDATA_BITS-1:0] m_axis_tdata
);
  import fdl_pkg::*;

  pipe_ctrl_t ctrl;
  logic       advance;

  logic                          st_valid;
  logic signed [SAMPLE_BITS-1:0] x1;
  logic signed [SAMPLE_BITS-1:0] x2;
  logic [FRAC_BITS-1:0]          frac;

  logic                          y_valid;
  logic signed [SAMPLE_BITS-1:0] y;
  logic [SAMPLE_BITS-1:0]        value;

  assign s_axis_tready = advance && !rst;
  assign ctrl = '{advance: advance, load: s_axis_tready && s_axis_tvalid};

  fdl_store #(
    .MAX_DELAY(MAX_DELAY),
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_store (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .sample($signed(s_axis_tdata[SAMPLE_BITS-1:0])),
    .delay(s_axis_tdata[SAMPLE_BITS +: DELAY_BITS]),
    .valid(st_valid),
    .x1(x1),
    .x2(x2),
    .frac(frac)
  );

  fdl_interp #(
    .SAMPLE_BITS(SAMPLE_BITS),
    .FRAC_BITS(FRAC_BITS)
  ) u_interp (
    .clk(clk),
    .rst(rst),
    .ctrl(ctrl),
    .valid_in(st_valid),
    .x1(x1),
    .x2(x2),
    .frac(frac),
    .y_valid(y_valid),
    .y(y)
  );

  fdl_out #(
    .SAMPLE_BITS(SAMPLE_BITS)
  ) u_out (
    .clk(clk),
    .rst(rst),
    .y_valid(y_valid),
    .y(y),
    .advance(advance),
    .tvalid(m_axis_tvalid),
    .tready(m_axis_tready),
    .value(value)
  );

  assign m_axis_tdata = OUT_TDATA_BITS'(value);

endmodule
